@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property must hold at every clock edge outside reset
`define WMC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// expression must never be true outside reset
`define WMC_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define WMC_ASSERT(lbl, clk, rst_n, prop, msg)
`define WMC_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

@@ rtl/core/wmc_pkg.sv @@
// shared constants, types and states of the motif counter
`timescale 1ns / 1ps
package wmc_pkg;
    localparam int MAX_WINDOW    = 256;
    localparam int MAX_MOTIF_LEN = 64;
    localparam int MAX_MOTIFS    = 64;
    localparam int SAMPLE_BITS   = 16;

    localparam int WIN_AW  = $clog2(MAX_WINDOW);
    localparam int FILL_W  = $clog2(MAX_WINDOW + 1);
    localparam int LEN_AW  = $clog2(MAX_MOTIF_LEN);
    localparam int LEN_W   = $clog2(MAX_MOTIF_LEN + 1);
    localparam int MOT_AW  = $clog2(MAX_MOTIFS);
    localparam int NUM_W   = $clog2(MAX_MOTIFS + 1);
    localparam int IDX_W   = $clog2(MAX_WINDOW + 2 * MAX_MOTIF_LEN + 2);
    localparam int SQ_W    = 2 * SAMPLE_BITS;
    localparam int ACC_W   = SQ_W + LEN_W;
    localparam int RADIUS_DEFAULT = 26;

    typedef enum logic [1:0] {
        REG_WINDOW_SIZE  = 2'd0,
        REG_MOTIF_LENGTH = 2'd1,
        REG_SKIP_STEP    = 2'd2,
        REG_RADIUS       = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_READ = 1'b1
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_CHECK, S_POS, S_CMP, S_WAIT, S_DEC,
        S_HIT, S_NEW, S_COPY, S_CFIN, S_DROP, S_OUT
    } state_t;

    // tag that travels beside each sample pair into the distance unit
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } wmc_tag_t;
endpackage

@@ rtl/core/wmc_ram.sv @@
// generic single write port ram with one registered read port
`timescale 1ns / 1ps
module wmc_ram #(
    parameter int DW = 16,
    parameter int AW = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/core/wmc_dist.sv @@
// squared distance unit: difference, square, accumulate
`timescale 1ns / 1ps
module wmc_dist
    import wmc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  wmc_tag_t               tag,
    input  logic [SAMPLE_BITS-1:0] a,
    input  logic [SAMPLE_BITS-1:0] b,
    output logic                   done,
    output logic [ACC_W-1:0]       sum
);
    wmc_tag_t               t1_reg, t2_reg;
    logic [SAMPLE_BITS-1:0] mag_reg;
    logic [SQ_W-1:0]        sq_reg;
    logic [ACC_W-1:0]       acc_reg, acc_next;
    logic                   done_reg;
    logic signed [SAMPLE_BITS:0] diff;
    logic [SAMPLE_BITS:0]   neg;

    assign diff = $signed({a[SAMPLE_BITS-1], a}) - $signed({b[SAMPLE_BITS-1], b});
    assign neg  = -diff;
    assign acc_next = (t2_reg.first ? '0 : acc_reg) + ACC_W'(sq_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_reg   <= '0;
            t2_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            t1_reg   <= tag;
            t2_reg   <= t1_reg;
            done_reg <= t2_reg.valid & t2_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= diff[SAMPLE_BITS] ? neg[SAMPLE_BITS-1:0] : diff[SAMPLE_BITS-1:0];
        sq_reg  <= SQ_W'(mag_reg) * SQ_W'(mag_reg);
        if (t2_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    assign done = done_reg;
    assign sum  = acc_reg;
endmodule

@@ rtl/core/window_motif_counter.sv @@
// top level: window store, motif table and the scanning sequencer
`timescale 1ns / 1ps
`include "assert_macros.svh"
// window_motif_counter collects signed q8.8 samples in a circular window
// store and, once the window is full, runs one scanning pass over it,
// comparing each start position with the stored motifs in turn, up to the
// first match, by squared distance against radius squared and four times
// radius squared. every input transfer gives exactly one result transfer.
// a sample push that does not fill the window passes through idle, check
// and output, and a table read through idle, read and output. a push that
// runs a pass compares, per start position, each motif in turn (reading its
// sample pairs, then waiting for and deciding on the distance), then records
// a match, moves on for an ambiguous position, or makes the 64-entry copy of
// a new motif into the motif memory; the distance unit takes one sample pair
// per cycle from the single read port of the window and motif memories.
// input and configuration are taken only while the sequencer is idle, but a
// finished result may still wait in the output register while the next
// item is taken. no clearing pass is needed after reset: the stores are
// only read where they were written.
module window_motif_counter
    import wmc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // sample_value[15:0], entry_index[21:16], zero pad
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // pass_done, similar_hits[8:1], new_motifs[16:9],
                                   // motifs_total[23:17], table_overflow[24],
                                   // entry_count[56:25], entry_valid[57], zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    state_t state_reg, state_next;

    // configuration registers
    logic [8:0]  ws_reg;
    logic [7:0]  ml_reg;
    logic [7:0]  ss_reg;
    logic [15:0] rad_reg;

    // sequencer state
    logic [WIN_AW-1:0] head_reg, head_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic              ovf_reg, ovf_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [MOT_AW-1:0] m_reg, m_next;
    logic [LEN_AW-1:0] k_reg, k_next;
    logic              amb_reg, amb_next;
    logic [7:0]        hits_reg, hits_next;
    logic [7:0]        news_reg, news_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  step_reg, step_next;
    logic [31:0]       r2_reg, r2_next;
    logic [ACC_W-1:0]  d2_reg, d2_next;
    logic              pass_reg, pass_next;
    logic              ev_reg, ev_next;
    logic [31:0]       cnt_reg, cnt_next;
    wmc_tag_t          rd_tag_reg, rd_tag_next;
    logic              cp_v_reg, cp_v_next;
    logic [LEN_AW-1:0] cp_k_reg;
    logic              mv_reg, mv_next;
    logic [63:0]       md_reg, md_next;

    // effective settings
    logic [8:0]        eff_w;
    logic [7:0]        len_raw;
    logic [LEN_W-1:0]  eff_l;
    logic [LEN_W-1:0]  eff_s;
    logic [15:0]       eff_r;
    logic [33:0]       r2x4;
    logic [FILL_W-1:0] drop;
    logic [IDX_W-1:0]  i_jump;

    // memory ports
    logic                   win_we;
    logic [WIN_AW-1:0]      win_waddr, win_raddr;
    logic [SAMPLE_BITS-1:0] win_rdata;
    logic                   mot_we;
    logic [MOT_AW+LEN_AW-1:0] mot_waddr;
    logic [SAMPLE_BITS-1:0] mot_wdata, mot_rdata;
    logic                   hit_we;
    logic [MOT_AW-1:0]      hit_waddr, hit_raddr;
    logic [31:0]            hit_wdata, hit_rdata;
    logic                   dist_done;
    logic [ACC_W-1:0]       dist_sum;

    logic in_xfer;
    logic [5:0] entry_index;

    assign s_tready    = (state_reg == S_IDLE);
    assign cfg_ready   = (state_reg == S_IDLE);
    assign in_xfer     = s_tvalid & s_tready;
    assign entry_index = s_tdata[21:16];
    assign m_tvalid    = mv_reg;
    assign m_tdata     = md_reg;

    // window size clamped to [2, MAX_WINDOW]
    always_comb
    begin
        eff_w = ws_reg;
        if (ws_reg < 9'd2)
        begin
            eff_w = 9'd2;
        end
        else if (ws_reg > 9'(MAX_WINDOW))
        begin
            eff_w = 9'(MAX_WINDOW);
        end
    end

    // motif length: zero or at least half the window gives window/4
    always_comb
    begin
        len_raw = ml_reg;
        if (ml_reg == 8'd0 || {1'b0, ml_reg, 1'b0} >= {1'b0, eff_w})
        begin
            len_raw = 8'(eff_w >> 2);
        end
        if (len_raw < 8'd1)
        begin
            len_raw = 8'd1;
        end
        if (len_raw > 8'(MAX_MOTIF_LEN))
        begin
            len_raw = 8'(MAX_MOTIF_LEN);
        end
        eff_l = len_raw[LEN_W-1:0];
    end

    // step outside (length/8, length] becomes the length
    always_comb
    begin
        if ({3'b0, ss_reg, 3'b0} <= 14'(eff_l) || {3'b0, ss_reg} > 11'(eff_l))
        begin
            eff_s = eff_l;
        end
        else
        begin
            eff_s = ss_reg[LEN_W-1:0];
        end
    end

    assign eff_r  = (rad_reg == 16'd0) ? 16'(RADIUS_DEFAULT) : rad_reg;
    assign r2x4   = {r2_reg, 2'b00};
    assign drop   = (i_reg > IDX_W'(fill_reg)) ? fill_reg : FILL_W'(i_reg);
    assign i_jump = i_reg + IDX_W'(step_reg) + IDX_W'(1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = (s_tuser == OP_READ) ? S_READ : S_CHECK;
                end
            end
            S_READ:  state_next = S_OUT;
            S_CHECK: state_next = (fill_reg >= FILL_W'(eff_w)) ? S_POS : S_OUT;
            S_POS:
            begin
                if ((i_reg + IDX_W'(len_reg)) < IDX_W'(fill_reg))
                begin
                    state_next = (num_reg == '0) ? S_NEW : S_CMP;
                end
                else
                begin
                    state_next = S_DROP;
                end
            end
            S_CMP:
            begin
                if (LEN_W'(k_reg) == len_reg - LEN_W'(1))
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (dist_done)
                begin
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (d2_reg < ACC_W'(r2_reg))
                begin
                    state_next = S_HIT;
                end
                else if (NUM_W'(m_reg) + NUM_W'(1) < num_reg)
                begin
                    state_next = S_CMP;
                end
                else
                begin
                    state_next = S_NEW;
                end
            end
            S_HIT:   state_next = S_POS;
            S_NEW:
            begin
                if (!amb_reg && num_reg < NUM_W'(MAX_MOTIFS))
                begin
                    state_next = S_COPY;
                end
                else
                begin
                    state_next = S_POS;
                end
            end
            S_COPY:
            begin
                if (k_reg == LEN_AW'(MAX_MOTIF_LEN - 1))
                begin
                    state_next = S_CFIN;
                end
            end
            S_CFIN:  state_next = S_POS;
            S_DROP:  state_next = S_OUT;
            S_OUT:
            begin
                if (!mv_reg || m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // memory port control
    always_comb
    begin
        win_we    = in_xfer && s_tuser == OP_PUSH && fill_reg < FILL_W'(MAX_WINDOW);
        win_waddr = head_reg + fill_reg[WIN_AW-1:0];
        win_raddr = head_reg + i_reg[WIN_AW-1:0] + WIN_AW'(k_reg);
        mot_we    = cp_v_reg;
        mot_waddr = {num_reg[MOT_AW-1:0], cp_k_reg};
        mot_wdata = (LEN_W'(cp_k_reg) < len_reg) ? win_rdata : '0;
        hit_raddr = (state_reg == S_IDLE) ? entry_index : m_reg;
        hit_we    = (state_reg == S_HIT) || (state_reg == S_CFIN);
        hit_waddr = (state_reg == S_HIT) ? m_reg : num_reg[MOT_AW-1:0];
        if (state_reg == S_HIT)
        begin
            hit_wdata = (hit_rdata == 32'hFFFF_FFFF) ? hit_rdata : hit_rdata + 32'd1;
        end
        else
        begin
            hit_wdata = 32'd1;
        end
    end

    // datapath registers
    always_comb
    begin
        head_next   = head_reg;
        fill_next   = fill_reg;
        num_next    = num_reg;
        ovf_next    = ovf_reg;
        i_next      = i_reg;
        m_next      = m_reg;
        k_next      = k_reg;
        amb_next    = amb_reg;
        hits_next   = hits_reg;
        news_next   = news_reg;
        len_next    = len_reg;
        step_next   = step_reg;
        r2_next     = r2_reg;
        d2_next     = d2_reg;
        pass_next   = pass_reg;
        ev_next     = ev_reg;
        cnt_next    = cnt_reg;
        rd_tag_next = '0;
        cp_v_next   = 1'b0;
        mv_next     = mv_reg & ~m_tready;
        md_next     = md_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    pass_next = 1'b0;
                    hits_next = '0;
                    news_next = '0;
                    cnt_next  = '0;
                    ev_next   = (s_tuser == OP_READ) &&
                                (NUM_W'(entry_index) < num_reg);
                    if (win_we)
                    begin
                        fill_next = fill_reg + FILL_W'(1);
                    end
                end
            end
            S_READ:
            begin
                cnt_next = ev_reg ? hit_rdata : 32'd0;
            end
            S_CHECK:
            begin
                i_next    = '0;
                len_next  = eff_l;
                step_next = eff_s;
                r2_next   = 32'(eff_r) * 32'(eff_r);
            end
            S_POS:
            begin
                m_next   = '0;
                k_next   = '0;
                amb_next = 1'b0;
            end
            S_CMP:
            begin
                rd_tag_next.valid = 1'b1;
                rd_tag_next.first = (k_reg == '0);
                rd_tag_next.last  = (LEN_W'(k_reg) == len_reg - LEN_W'(1));
                k_next = k_reg + LEN_AW'(1);
            end
            S_WAIT:
            begin
                d2_next = dist_sum;
            end
            S_DEC:
            begin
                k_next = '0;
                if (d2_reg >= ACC_W'(r2_reg))
                begin
                    if (d2_reg > ACC_W'(r2_reg) && d2_reg < ACC_W'(r2x4))
                    begin
                        amb_next = 1'b1;
                    end
                    m_next = m_reg + MOT_AW'(1);
                end
            end
            S_HIT:
            begin
                if (hits_reg != 8'hFF)
                begin
                    hits_next = hits_reg + 8'd1;
                end
                i_next = i_jump;
            end
            S_NEW:
            begin
                k_next = '0;
                if (amb_reg)
                begin
                    i_next = i_reg + IDX_W'(1);
                end
                else if (num_reg >= NUM_W'(MAX_MOTIFS))
                begin
                    ovf_next = 1'b1;
                    i_next   = i_jump;
                end
            end
            S_COPY:
            begin
                cp_v_next = 1'b1;
                k_next    = k_reg + LEN_AW'(1);
            end
            S_CFIN:
            begin
                num_next = num_reg + NUM_W'(1);
                if (news_reg != 8'hFF)
                begin
                    news_next = news_reg + 8'd1;
                end
                i_next = i_jump;
            end
            S_DROP:
            begin
                pass_next = 1'b1;
                head_next = head_reg + drop[WIN_AW-1:0];
                fill_next = fill_reg - drop;
            end
            S_OUT:
            begin
                if (!mv_reg || m_tready)
                begin
                    mv_next = 1'b1;
                    md_next = {6'd0, ev_reg, cnt_reg, ovf_reg, num_reg,
                               news_reg, hits_reg, pass_reg};
                end
            end
            default:
            begin
                mv_next = mv_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ws_reg     <= 9'(MAX_WINDOW);
            ml_reg     <= '0;
            ss_reg     <= '0;
            rad_reg    <= 16'(RADIUS_DEFAULT);
            head_reg   <= '0;
            fill_reg   <= '0;
            num_reg    <= '0;
            ovf_reg    <= 1'b0;
            rd_tag_reg <= '0;
            cp_v_reg   <= 1'b0;
            mv_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            fill_reg   <= fill_next;
            num_reg    <= num_next;
            ovf_reg    <= ovf_next;
            rd_tag_reg <= rd_tag_next;
            cp_v_reg   <= cp_v_next;
            mv_reg     <= mv_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_WINDOW_SIZE:  ws_reg  <= cfg_data[8:0];
                    REG_MOTIF_LENGTH: ml_reg  <= cfg_data[7:0];
                    REG_SKIP_STEP:    ss_reg  <= cfg_data[7:0];
                    REG_RADIUS:       rad_reg <= cfg_data;
                    default:          ws_reg  <= ws_reg;
                endcase
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        i_reg    <= i_next;
        m_reg    <= m_next;
        k_reg    <= k_next;
        amb_reg  <= amb_next;
        hits_reg <= hits_next;
        news_reg <= news_next;
        len_reg  <= len_next;
        step_reg <= step_next;
        r2_reg   <= r2_next;
        d2_reg   <= d2_next;
        pass_reg <= pass_next;
        ev_reg   <= ev_next;
        cnt_reg  <= cnt_next;
        cp_k_reg <= k_reg;
        md_reg   <= md_next;
    end

    // window store, circular
    wmc_ram #(.DW(SAMPLE_BITS), .AW(WIN_AW)) u_win_ram (
        .clk   (clk),
        .we    (win_we),
        .waddr (win_waddr),
        .wdata (s_tdata[SAMPLE_BITS-1:0]),
        .raddr (win_raddr),
        .rdata (win_rdata)
    );

    // motif samples, one row of MAX_MOTIF_LEN per motif
    wmc_ram #(.DW(SAMPLE_BITS), .AW(MOT_AW + LEN_AW)) u_mot_ram (
        .clk   (clk),
        .we    (mot_we),
        .waddr (mot_waddr),
        .wdata (mot_wdata),
        .raddr ({m_reg, k_reg}),
        .rdata (mot_rdata)
    );

    // motif hit counts, read-modify-write in hit state
    wmc_ram #(.DW(32), .AW(MOT_AW)) u_hit_ram (
        .clk   (clk),
        .we    (hit_we),
        .waddr (hit_waddr),
        .wdata (hit_wdata),
        .raddr (hit_raddr),
        .rdata (hit_rdata)
    );

    wmc_dist u_dist (
        .clk   (clk),
        .rst_n (rst_n),
        .tag   (rd_tag_reg),
        .a     (win_rdata),
        .b     (mot_rdata),
        .done  (dist_done),
        .sum   (dist_sum)
    );

    `WMC_ASSERT(a_num_bound, clk, rst_n, num_reg <= NUM_W'(MAX_MOTIFS), "motif count past table")
    `WMC_ASSERT(a_fill_bound, clk, rst_n, fill_reg <= FILL_W'(MAX_WINDOW), "fill past window")
    `WMC_NEVER(a_copy_full, clk, rst_n, cp_v_reg && num_reg >= NUM_W'(MAX_MOTIFS), "copy into full table")
    `WMC_ASSERT(a_accept_busy, clk, rst_n, in_xfer |=> state_reg != S_IDLE, "accept did not start work")
endmodule
